[rtl/utd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to display charset package
// Request payload types, lookup result type and the code point table.
// ----------------------------------------------------------------------------
package utd_pkg;

    localparam int POINT_WIDTH = 24;
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] NUL_BYTE = 8'h00;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } in_req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       keep;
        logic       end_mark;
    } out_req_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] rom;
    } map_result_t;

    function automatic map_result_t map_point(input logic [POINT_WIDTH-1:0] point);
        map_result_t res;
        res.hit = 1'b1;
        res.rom = 8'h00;
        case (point)
            24'h00C2B0: res.rom = 8'h07;
            24'h00C2AB: res.rom = 8'h14;
            24'h00C2BB: res.rom = 8'h15;
            24'h00005E: res.rom = 8'h1D;
            24'h00C2A4: res.rom = 8'h24;
            24'h00C2A1: res.rom = 8'h40;
            24'h00C384: res.rom = 8'h5B;
            24'h00C396: res.rom = 8'h5C;
            24'h00C391: res.rom = 8'h5D;
            24'h00C39C: res.rom = 8'h5E;
            24'h00C2A7: res.rom = 8'h5F;
            24'h00C2BF: res.rom = 8'h60;
            24'h00C3A4: res.rom = 8'h7B;
            24'h00C3B6: res.rom = 8'h7C;
            24'h00C3B1: res.rom = 8'h7D;
            24'h00C3BC: res.rom = 8'h7E;
            24'h00C3A0: res.rom = 8'h7F;
            24'h00C2B9: res.rom = 8'h81;
            24'h00C2B2: res.rom = 8'h82;
            24'h00C2B3: res.rom = 8'h83;
            24'h00C2BD: res.rom = 8'h8A;
            24'h00C2BC: res.rom = 8'h8B;
            24'h00C2B1: res.rom = 8'h8C;
            24'hE289A5: res.rom = 8'h8D;
            24'hE289A4: res.rom = 8'h8E;
            24'h00C2B5: res.rom = 8'h8F;
            24'hE299AA: res.rom = 8'h90;
            24'hE299AB: res.rom = 8'h91;
            24'hE299A5: res.rom = 8'h93;
            24'hE299A6: res.rom = 8'h94;
            24'hE2809C: res.rom = 8'h98;
            24'hE2809D: res.rom = 8'h99;
            24'h00CEB1: res.rom = 8'h9C;
            24'h00CEB5: res.rom = 8'h9D;
            24'h000040: res.rom = 8'hA0;
            24'h00C2A3: res.rom = 8'hA1;
            24'h000024: res.rom = 8'hA2;
            24'h00C2A5: res.rom = 8'hA3;
            24'h00C3A8: res.rom = 8'hA4;
            24'h00C3A9: res.rom = 8'hA5;
            24'h00C3B9: res.rom = 8'hA6;
            24'h00C3AC: res.rom = 8'hA7;
            24'h00C3B2: res.rom = 8'hA8;
            24'h00C387: res.rom = 8'hA9;
            24'h00C398: res.rom = 8'hAB;
            24'h00C3B8: res.rom = 8'hAC;
            24'h00C385: res.rom = 8'hAE;
            24'h00C3A5: res.rom = 8'hAF;
            24'h00C2A2: res.rom = 8'hB1;
            24'h00CEBB: res.rom = 8'hB4;
            24'h00CEA9: res.rom = 8'hB5;
            24'h00CF80: res.rom = 8'hB6;
            24'h00CEA8: res.rom = 8'hB7;
            24'h00CEA3: res.rom = 8'hB8;
            24'h00CEB8: res.rom = 8'hB9;
            24'h00CE9E: res.rom = 8'hBA;
            24'hE2978F: res.rom = 8'hBB;
            24'h00C386: res.rom = 8'hBC;
            24'h00C3A6: res.rom = 8'hBD;
            24'h00C39F: res.rom = 8'hBE;
            24'h00C389: res.rom = 8'hBF;
            24'h00CE93: res.rom = 8'hC0;
            24'h00CE9B: res.rom = 8'hC1;
            24'h00CEA0: res.rom = 8'hC2;
            24'h00005F: res.rom = 8'hC4;
            24'h00C388: res.rom = 8'hC5;
            24'h00C38A: res.rom = 8'hC6;
            24'h00C3AA: res.rom = 8'hC7;
            24'h00C3A7: res.rom = 8'hC8;
            24'h00007E: res.rom = 8'hCE;
            24'h00C2B7: res.rom = 8'hDD;
            24'h00C381: res.rom = 8'hE2;
            24'h00C38D: res.rom = 8'hE3;
            24'h00C393: res.rom = 8'hE4;
            24'h00C39A: res.rom = 8'hE5;
            24'h00C39D: res.rom = 8'hE6;
            24'h00C3A1: res.rom = 8'hE7;
            24'h00C3AD: res.rom = 8'hE8;
            24'h00C3B3: res.rom = 8'hE9;
            24'h00C3BA: res.rom = 8'hEA;
            24'h00C3BD: res.rom = 8'hEB;
            24'h00C394: res.rom = 8'hEC;
            24'h00C3B4: res.rom = 8'hED;
            24'h00C48C: res.rom = 8'hF0;
            24'h00C49A: res.rom = 8'hF1;
            24'h00C598: res.rom = 8'hF2;
            24'h00C5A0: res.rom = 8'hF3;
            24'h00C5BD: res.rom = 8'hF4;
            24'h00C48D: res.rom = 8'hF5;
            24'h00C49B: res.rom = 8'hF6;
            24'h00C599: res.rom = 8'hF7;
            24'h00C5A1: res.rom = 8'hF8;
            24'h00C5BE: res.rom = 8'hF9;
            24'h00005B: res.rom = 8'hFA;
            24'h00005C: res.rom = 8'hFB;
            24'h00005D: res.rom = 8'hFC;
            24'h00007B: res.rom = 8'hFD;
            24'h00007C: res.rom = 8'hFE;
            24'h00C2A6: res.rom = 8'hFE;
            24'h00007D: res.rom = 8'hFF;
            default:
            begin
                res.hit = 1'b0;
                res.rom = 8'h00;
            end
        endcase
        return res;
    endfunction

endpackage

[rtl/utd_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to display charset stream interface
// Valid/ready channel that carries one request of a given payload type.
// ----------------------------------------------------------------------------
interface utd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

[rtl/utd_map_lookup.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to display charset code point lookup
// Matches the accumulated code point against the display ROM table.
// ----------------------------------------------------------------------------
module utd_map_lookup #(
    parameter int ACC_WIDTH = 32
) (
    input  logic [ACC_WIDTH-1:0] acc,
    output utd_pkg::map_result_t result
);

    logic                upper_zero;
    utd_pkg::map_result_t table_res;

    generate
        if (ACC_WIDTH > utd_pkg::POINT_WIDTH) begin : g_upper
            assign upper_zero = (acc[ACC_WIDTH-1:utd_pkg::POINT_WIDTH] == '0);
        end
        else begin : g_no_upper
            assign upper_zero = 1'b1;
        end
    endgenerate

    assign table_res = utd_pkg::map_point(acc[utd_pkg::POINT_WIDTH-1:0]);

    always_comb
    begin
        result.hit = table_res.hit & upper_zero;
        result.rom = table_res.rom;
    end

endmodule

[rtl/utf8_to_display_charset_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to display charset converter
// Rewrites a UTF-8 byte stream into display character ROM codes.
// ----------------------------------------------------------------------------
// The core takes one byte request per clock while the output is not stalled
// and returns exactly one result request for each: an input register feeds the
// accumulator update and table match, whose outcome lands in the result
// register. The code accumulator is updated in the same cycle a byte leaves
// the input register, so back-to-back bytes of one code point run at full
// rate. A stall on the output holds both loaded registers and drops ready.
module utf8_to_display_charset_core #(
    parameter int ACC_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    utd_stream_if.sink    in_stream,
    utd_stream_if.source  out_stream
);

    logic                 in_valid_reg;
    utd_pkg::in_req_t     in_data_reg;
    logic                 out_valid_reg;
    utd_pkg::out_req_t    out_data_reg;
    utd_pkg::out_req_t    out_data_next;
    logic [ACC_WIDTH-1:0] acc_reg;
    logic [ACC_WIDTH-1:0] acc_next;
    logic [ACC_WIDTH-1:0] acc_shift;
    logic                 out_free;
    logic                 advance;
    utd_pkg::map_result_t map_res;

    assign out_free = ~out_valid_reg | out_stream.ready;
    assign advance = in_valid_reg & out_free;
    assign in_stream.ready = ~in_valid_reg | advance;

    always_comb
    begin
        if (in_data_reg.in_byte < utd_pkg::ASCII_LIMIT)
        begin
            acc_shift = {{(ACC_WIDTH-8){1'b0}}, in_data_reg.in_byte};
        end
        else
        begin
            acc_shift = {acc_reg[ACC_WIDTH-9:0], in_data_reg.in_byte};
        end
    end

    utd_map_lookup #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_lookup (
        .acc    (acc_shift),
        .result (map_res)
    );

    always_comb
    begin
        out_data_next.end_mark = in_data_reg.last_byte;
        acc_next = '0;
        if (in_data_reg.in_byte == utd_pkg::NUL_BYTE)
        begin
            out_data_next.out_byte = utd_pkg::NUL_BYTE;
            out_data_next.keep = 1'b1;
            out_data_next.end_mark = 1'b1;
        end
        else if (map_res.hit)
        begin
            out_data_next.out_byte = map_res.rom;
            out_data_next.keep = 1'b1;
        end
        else if (in_data_reg.in_byte[7])
        begin
            // Part of a multibyte sequence: drop the byte and keep collecting.
            out_data_next.out_byte = 8'h00;
            out_data_next.keep = 1'b0;
            acc_next = acc_shift;
        end
        else
        begin
            out_data_next.out_byte = in_data_reg.in_byte;
            out_data_next.keep = 1'b1;
        end
        if (in_data_reg.last_byte)
        begin
            acc_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            if (in_stream.ready)
            begin
                in_valid_reg <= in_stream.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_stream.ready && in_stream.valid)
        begin
            in_data_reg <= in_stream.data;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_stream.valid = out_valid_reg;
    assign out_stream.data = out_data_reg;

endmodule
